/* rtl/hrsc_pkg.sv */
package hrsc_pkg;

  // Field widths
  localparam int FsrW      = 14;
  localparam int CodeW     = 16;
  localparam int ByteW     = 8;
  localparam int FieldW    = 15;
  localparam int MagW      = 15;
  localparam int TempW     = 18;
  localparam int ProdW     = CodeW + FsrW + 1;
  localparam int SqW       = 2 * (FieldW - 1);
  localparam int SumW      = SqW + 2;

  // Square root chain: one cell per radicand bit pair
  localparam int SqrtSteps = 16;
  localparam int RadW      = 2 * SqrtSteps;
  localparam int RootW     = SqrtSteps + 2;
  localparam int RemW      = SqrtSteps + 4;

  // Scaling constants
  localparam logic [FsrW-1:0]         FsrReset    = 14'd10000;
  localparam int                      RangeShift  = 15;
  localparam logic signed [16:0]      DieT0Code   = 17'sd17522;
  localparam logic signed [TempW-1:0] DieBase     = 18'sd2500;
  localparam logic [18:0]             DieRecip    = 19'd349525;
  localparam int                      DieRecipSh  = 20;
  localparam logic signed [TempW-1:0] RtdOffset   = 18'sd25600;

  // Results that do not depend on the root, carried alongside the chain
  typedef struct packed {
    logic signed [FieldW-1:0] field_x;
    logic signed [FieldW-1:0] field_y;
    logic signed [FieldW-1:0] field_z;
    logic signed [TempW-1:0]  die_temp;
    logic signed [TempW-1:0]  rtd_temp;
    logic                     rtd_fault;
  } hrsc_side_t;

  // Partial state of the restoring square root
  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    logic [RadW-1:0]  radicand;
  } hrsc_root_t;

  // One finished result item
  typedef struct packed {
    hrsc_side_t      side;
    logic [MagW-1:0] magnitude;
  } hrsc_result_t;

endpackage

/* rtl/hrsc_front.sv */
module hrsc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [hrsc_pkg::CodeW-1:0]    axis_x_code,
  input  logic [hrsc_pkg::CodeW-1:0]    axis_y_code,
  input  logic [hrsc_pkg::CodeW-1:0]    axis_z_code,
  input  logic [hrsc_pkg::CodeW-1:0]    die_temp_code,
  input  logic [hrsc_pkg::ByteW-1:0]    rtd_high_byte,
  input  logic [hrsc_pkg::ByteW-1:0]    rtd_low_byte,
  input  logic [hrsc_pkg::FsrW-1:0]     full_scale_range,
  output logic                          out_valid,
  output hrsc_pkg::hrsc_side_t          side,
  output logic [hrsc_pkg::RadW-1:0]     radicand
);
  import hrsc_pkg::*;

  // Division by 32768 truncated toward zero.
  function automatic logic signed [FieldW-1:0] axis_trunc(input logic signed [ProdW-1:0] p);
    logic signed [ProdW:0] a;
    a = p[ProdW-1] ? ((ProdW+1)'(p) + (ProdW+1)'(32767)) : (ProdW+1)'(p);
    return a[RangeShift+FieldW-1:RangeShift];
  endfunction

  // Stage 1 registers
  logic                     v1;
  logic signed [ProdW-1:0]  prod_x, prod_y, prod_z;
  logic [17:0]              die_n1;
  logic                     die_neg1;
  logic signed [TempW-1:0]  rtd1;
  logic                     fault1;

  // Stage 2 registers
  logic                     v2;
  logic signed [FieldW-1:0] fx2, fy2, fz2;
  logic [17:0]              die_n2;
  logic [16:0]              die_q0;
  logic                     die_neg2;
  logic signed [TempW-1:0]  rtd2;
  logic                     fault2;

  // Stage 3 registers
  logic                     v3;
  logic signed [FieldW-1:0] fx3, fy3, fz3;
  logic [SqW-1:0]           sq_x, sq_y, sq_z;
  logic signed [TempW-1:0]  die3;
  logic signed [TempW-1:0]  rtd3;
  logic                     fault3;

  // Stage 1 logic: axis products, die offset times five, RTD scaling
  logic signed [16:0]       die_d;
  logic [15:0]              die_abs;
  logic [14:0]              rtd_adc;
  logic [21:0]              rtd_x100;

  always_comb begin
    die_d    = $signed({1'b0, die_temp_code}) - DieT0Code;
    die_abs  = die_d[16] ? 16'(-die_d) : 16'(die_d);
    rtd_adc  = {rtd_high_byte, rtd_low_byte[ByteW-1:1]};
    rtd_x100 = 22'({rtd_adc, 6'b0}) + 22'({rtd_adc, 5'b0}) + 22'({rtd_adc, 2'b0});
  end

  // Stage 2 logic: reciprocal multiply for the division by three
  logic [36:0]              die_prod;
  assign die_prod = 37'(die_n1) * 37'(DieRecip);

  // Stage 3 logic: squares and the one-step quotient correction
  logic signed [2*FieldW-1:0] px, py, pz;
  logic [18:0]                die_r;
  logic [16:0]                die_q;

  always_comb begin
    px    = fx2 * fx2;
    py    = fy2 * fy2;
    pz    = fz2 * fz2;
    die_r = 19'(die_n2) - (19'({die_q0, 1'b0}) + 19'(die_q0));
    die_q = (die_r >= 19'd3) ? die_q0 + 17'd1 : die_q0;
  end

  // Valid bits of the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  // Payload of the front stages
  always_ff @(posedge clk) begin
    if (en) begin
      prod_x   <= $signed(axis_x_code) * $signed({1'b0, full_scale_range});
      prod_y   <= $signed(axis_y_code) * $signed({1'b0, full_scale_range});
      prod_z   <= $signed(axis_z_code) * $signed({1'b0, full_scale_range});
      die_n1   <= 18'({die_abs, 2'b00}) + 18'(die_abs);
      die_neg1 <= die_d[16];
      rtd1     <= $signed({1'b0, rtd_x100[21:5]}) - RtdOffset;
      fault1   <= rtd_low_byte[0];

      fx2      <= axis_trunc(prod_x);
      fy2      <= axis_trunc(prod_y);
      fz2      <= axis_trunc(prod_z);
      die_n2   <= die_n1;
      die_q0   <= die_prod[DieRecipSh+16:DieRecipSh];
      die_neg2 <= die_neg1;
      rtd2     <= rtd1;
      fault2   <= fault1;

      fx3      <= fx2;
      fy3      <= fy2;
      fz3      <= fz2;
      sq_x     <= px[SqW-1:0];
      sq_y     <= py[SqW-1:0];
      sq_z     <= pz[SqW-1:0];
      die3     <= die_neg2 ? DieBase - $signed({1'b0, die_q})
                           : DieBase + $signed({1'b0, die_q});
      rtd3     <= rtd2;
      fault3   <= fault2;

      side.field_x   <= fx3;
      side.field_y   <= fy3;
      side.field_z   <= fz3;
      side.die_temp  <= die3;
      side.rtd_temp  <= rtd3;
      side.rtd_fault <= fault3;
      radicand       <= RadW'(SumW'(sq_x) + SumW'(sq_y) + SumW'(sq_z));
    end
  end

endmodule

/* rtl/hrsc_root_cell.sv */
module hrsc_root_cell #(
  parameter int Step = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  hrsc_pkg::hrsc_root_t  in_state,
  input  hrsc_pkg::hrsc_side_t  in_side,
  output logic                  out_valid,
  output hrsc_pkg::hrsc_root_t  out_state,
  output hrsc_pkg::hrsc_side_t  out_side
);
  import hrsc_pkg::*;

  // One restoring step: bring down the next bit pair and try the trial subtrahend.
  logic [1:0]       pair;
  logic [RootW-1:0] root_s;
  logic [RemW-1:0]  rem_s;
  logic [RemW-1:0]  trial;
  logic             take;
  hrsc_root_t       state_next;

  always_comb begin
    pair       = in_state.radicand[RadW-1-2*Step -: 2];
    root_s     = {in_state.root[RootW-2:0], 1'b0};
    rem_s      = {in_state.rem[RemW-3:0], pair};
    trial      = RemW'(root_s) + RemW'(1);
    take       = RemW'(root_s) < rem_s;
    state_next = in_state;
    state_next.rem  = take ? rem_s - trial : rem_s;
    state_next.root = take ? root_s + RootW'(2) : root_s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_state <= state_next;
      out_side  <= in_side;
    end
  end

endmodule

/* rtl/hall_and_rtd_sample_converter.sv */
// Converts one Hall and RTD sample set per item into scaled fields, the field
// magnitude and two temperatures. A new item is taken every clock cycle while
// the output buffer has room; each result passes through four front stages
// (axis multiply, truncating divide, squaring, sum of squares, with the die
// temperature's divide by three done alongside), sixteen square root cells that
// each settle one bit of the magnitude, and the output register. A two-entry
// output buffer takes the last result while the consumer stalls; s_tready falls
// once it fills, and no item is lost. The user must write full_scale_range through
// cfg_wr_en and cfg_wr_data only while the block is idle, which it does not enforce.
module hall_and_rtd_sample_converter (
  input  logic        clk,
  input  logic        rst,
  // Configuration: full_scale_range
  input  logic        cfg_wr_en,
  input  logic [13:0] cfg_wr_data,
  // Input items
  input  logic        s_tvalid,
  output logic        s_tready,
  // axis_x_code [15:0], axis_y_code [31:16], axis_z_code [47:32],
  // die_temp_code [63:48], rtd_high_byte [71:64], rtd_low_byte [79:72]
  input  logic [79:0] s_tdata,
  // Result items
  output logic        m_tvalid,
  input  logic        m_tready,
  // field_x [14:0], field_y [29:15], field_z [44:30], field_magnitude [59:45],
  // die_temp [77:60], rtd_temp [95:78]
  output logic [95:0] m_tdata,
  // rtd_fault [0]
  output logic [0:0]  m_tuser
);
  import hrsc_pkg::*;

  logic [FsrW-1:0] full_scale_range;
  logic            en;

  logic            front_valid;
  hrsc_side_t      front_side;
  logic [RadW-1:0] front_radicand;

  logic            chain_valid [SqrtSteps+1];
  hrsc_root_t      chain_state [SqrtSteps+1];
  hrsc_side_t      chain_side  [SqrtSteps+1];

  logic            o_valid;
  hrsc_result_t    o_res;
  logic            skid_valid;
  hrsc_result_t    skid_res;
  hrsc_result_t    pipe_res;
  logic            push;

  // Full-scale range register
  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale_range <= FsrReset;
    end else if (cfg_wr_en) begin
      full_scale_range <= cfg_wr_data;
    end
  end

  // The whole pipeline moves while the output buffer has room.
  assign en       = !skid_valid;
  assign s_tready = en;

  hrsc_front u_front (
    .clk              (clk),
    .rst              (rst),
    .en               (en),
    .in_valid         (s_tvalid),
    .axis_x_code      (s_tdata[15:0]),
    .axis_y_code      (s_tdata[31:16]),
    .axis_z_code      (s_tdata[47:32]),
    .die_temp_code    (s_tdata[63:48]),
    .rtd_high_byte    (s_tdata[71:64]),
    .rtd_low_byte     (s_tdata[79:72]),
    .full_scale_range (full_scale_range),
    .out_valid        (front_valid),
    .side             (front_side),
    .radicand         (front_radicand)
  );

  // Head of the square root chain
  always_comb begin
    chain_valid[0]          = front_valid;
    chain_side[0]           = front_side;
    chain_state[0].rem      = '0;
    chain_state[0].root     = '0;
    chain_state[0].radicand = front_radicand;
  end

  // Square root chain, one result bit per cell
  for (genvar i = 0; i < SqrtSteps; i++) begin : g_cell
    hrsc_root_cell #(
      .Step (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (chain_valid[i]),
      .in_state  (chain_state[i]),
      .in_side   (chain_side[i]),
      .out_valid (chain_valid[i+1]),
      .out_state (chain_state[i+1]),
      .out_side  (chain_side[i+1])
    );
  end

  always_comb begin
    pipe_res.side      = chain_side[SqrtSteps];
    pipe_res.magnitude = chain_state[SqrtSteps].root[MagW:1];
    push               = en && chain_valid[SqrtSteps];
  end

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid    <= 1'b0;
      skid_valid <= 1'b0;
    end else if (o_valid && !m_tready) begin
      if (push) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      o_valid    <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      o_valid    <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (o_valid && !m_tready) begin
      if (push) begin
        skid_res <= pipe_res;
      end
    end else if (skid_valid) begin
      o_res <= skid_res;
    end else if (push) begin
      o_res <= pipe_res;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {o_res.side.rtd_temp, o_res.side.die_temp, o_res.magnitude,
                     o_res.side.field_z, o_res.side.field_y, o_res.side.field_x};
  assign m_tuser  = o_res.side.rtd_fault;

endmodule

/* tb/tb_hall_and_rtd_sample_converter.sv */
module tb_hall_and_rtd_sample_converter;
  import hrsc_pkg::*;

  // Conversion constants
  localparam longint AxisDivisor  = 32768;
  localparam longint DieZeroCode  = 17522;
  localparam longint DieCodeStep  = 60;
  localparam longint DieOffset    = 2500;
  localparam longint RtdZeroShift = 25600;
  localparam int     RandomPerSet = 165;
  localparam int     SettleCycles = 40;

  // One expected or observed result item
  typedef struct packed {
    logic signed [FieldW-1:0] field_x;
    logic signed [FieldW-1:0] field_y;
    logic signed [FieldW-1:0] field_z;
    logic [MagW-1:0]          magnitude;
    logic signed [TempW-1:0]  die_temp;
    logic signed [TempW-1:0]  rtd_temp;
    logic                     rtd_fault;
  } conversion_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [FsrW-1:0]   cfg_wr_data = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [79:0]       s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [95:0]       m_tdata;
  logic [0:0]        m_tuser;

  logic [79:0]       sample_q[$];
  conversion_t       conversion_q[$];
  logic [FsrW-1:0]   range_setting = FsrReset;
  logic              taken = 1'b0;
  int                burst_left = 1;
  int                gap_left = 0;
  int                samples_sent = 0;
  int                results_seen = 0;
  int                error_count = 0;
  int                settings_used = 1;

  hall_and_rtd_sample_converter uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

  always #10 clk = ~clk;

  // Works out the result item for one sample set under the given range.
  function automatic conversion_t convert_sample(logic [79:0] sample, logic [FsrW-1:0] fsr);
    conversion_t res;
    longint      bx;
    longint      by;
    longint      bz;
    longint      sum_sq;
    longint      die;
    longint      adc;
    longint      rtd;
    logic [16:0] root;
    logic [16:0] trial;
    bx = (longint'($signed(sample[15:0])) * longint'(fsr)) / AxisDivisor;
    by = (longint'($signed(sample[31:16])) * longint'(fsr)) / AxisDivisor;
    bz = (longint'($signed(sample[47:32])) * longint'(fsr)) / AxisDivisor;
    sum_sq = bx * bx + by * by + bz * bz;
    // Floor square root, settling one bit at a time from the top.
    root = '0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (17'd1 << b);
      if (longint'(trial) * longint'(trial) <= sum_sq) begin
        root = trial;
      end
    end
    die = DieOffset + ((longint'(sample[63:48]) - DieZeroCode) * 100) / DieCodeStep;
    adc = longint'({sample[71:64], sample[79:73]});
    rtd = (adc * 100) / 32 - RtdZeroShift;
    res.field_x   = bx[FieldW-1:0];
    res.field_y   = by[FieldW-1:0];
    res.field_z   = bz[FieldW-1:0];
    res.magnitude = root[MagW-1:0];
    res.die_temp  = die[TempW-1:0];
    res.rtd_temp  = rtd[TempW-1:0];
    res.rtd_fault = sample[72];
    return res;
  endfunction

  // Axis code with a bias towards the extremes and small values.
  function automatic logic [CodeW-1:0] random_axis_code();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(int'($urandom_range(0, 16)) - 8);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic queue_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                              logic [15:0] die, logic [7:0] hi, logic [7:0] lo);
    sample_q.push_back({lo, hi, die, z, y, x});
  endtask

  // Waits until every queued item has gone in and every result has come out.
  task automatic drain();
    while (sample_q.size() != 0 || s_tvalid || conversion_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_range(logic [FsrW-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    range_setting = value;
    settings_used++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Sender: bursts of items separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        s_tdata <= sample_q.pop_front();
        s_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: epochs of always ready, periodic stalls or random stalls.
  int stall_kind = 0;
  int stall_left = 0;
  int stall_period = 1;
  int stall_len = 0;
  int stall_pos = 0;
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_kind = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
      stall_period = $urandom_range(2, 24);
      stall_len = $urandom_range(1, stall_period - 1);
      stall_pos = 0;
    end
    stall_left--;
    stall_pos = (stall_pos + 1) % stall_period;
    case (stall_kind)
      0: m_tready <= 1'b1;
      1: m_tready <= (stall_pos >= stall_len);
      2: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Accepted input items: predict their results.
  always @(posedge clk) begin
    taken <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      conversion_q.push_back(convert_sample(s_tdata, range_setting));
      samples_sent++;
    end
  end

  // Accepted result items: compare with the oldest prediction.
  always @(posedge clk) begin
    conversion_t want;
    conversion_t got;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      got.field_x   = m_tdata[14:0];
      got.field_y   = m_tdata[29:15];
      got.field_z   = m_tdata[44:30];
      got.magnitude = m_tdata[59:45];
      got.die_temp  = m_tdata[77:60];
      got.rtd_temp  = m_tdata[95:78];
      got.rtd_fault = m_tuser[0];
      if (conversion_q.size() == 0) begin
        $error("result item with no sample set outstanding");
        error_count++;
      end else begin
        want = conversion_q.pop_front();
        check_field("field_x", want.field_x, got.field_x);
        check_field("field_y", want.field_y, got.field_y);
        check_field("field_z", want.field_z, got.field_z);
        check_field("field_magnitude", want.magnitude, got.magnitude);
        check_field("die_temp", want.die_temp, got.die_temp);
        check_field("rtd_temp", want.rtd_temp, got.rtd_temp);
        check_field("rtd_fault", want.rtd_fault, got.rtd_fault);
      end
    end
  end

  // Stimulus and phase control.
  initial begin
    logic [FsrW-1:0] range_plan[6];
    range_plan = '{14'd2500, 14'd5000, 14'd16383, 14'd0, 14'd0, FsrReset};
    range_plan[4] = FsrW'($urandom_range(1, 16382));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed sets at the reset range: code extremes, die and RTD corners.
    queue_sample(16'h0000, 16'h0000, 16'h0000, 16'd17522, 8'h00, 8'h00);
    queue_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 8'hFF, 8'hFF);
    queue_sample(16'h8000, 16'h8000, 16'h8000, 16'h0000, 8'hFF, 8'hFE);
    queue_sample(16'hFFFF, 16'h0001, 16'hFFFF, 16'd17521, 8'h80, 8'h01);
    queue_sample(16'h0001, 16'hFFFF, 16'h0001, 16'd17523, 8'h7F, 8'hFF);
    queue_sample(16'h7FFF, 16'h8000, 16'h0000, 16'd17462, 8'h40, 8'h00);
    queue_sample(16'h8001, 16'd3277, 16'hF333, 16'd1, 8'h01, 8'h02);
    queue_sample(16'd12345, 16'hCFC7, 16'd30000, 16'd40000, 8'h55, 8'hAA);
    queue_sample(16'hFFFC, 16'h0003, 16'h0000, 16'd17582, 8'hAA, 8'h55);
    queue_sample(16'h7FFF, 16'h0000, 16'h0000, 16'd17581, 8'h00, 8'h01);
    queue_sample(16'h0000, 16'h8000, 16'h0000, 16'd17463, 8'h00, 8'h03);
    queue_sample(16'h0000, 16'h0000, 16'hFFFF, 16'd32768, 8'hC8, 8'h00);
    drain();

    // Random sets under each range setting, the extremes among them.
    foreach (range_plan[p]) begin
      write_range(range_plan[p]);
      for (int n = 0; n < RandomPerSet; n++) begin
        queue_sample(random_axis_code(), random_axis_code(), random_axis_code(),
                     16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
      end
      drain();
    end

    if (conversion_q.size() != 0) begin
      $error("%0d result items never arrived", conversion_q.size());
      error_count++;
    end
    $display("Converted %0d sample sets and checked %0d result items", samples_sent,
             results_seen);
    $display("across %0d full scale range settings, 0 and 16383 included.", settings_used);
    if (error_count == 0) begin
      $display("tb_hall_and_rtd_sample_converter passed");
    end else begin
      $display("tb_hall_and_rtd_sample_converter failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5000000;
    $display("tb_hall_and_rtd_sample_converter failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/hrsc_pkg.sv
rtl/hrsc_front.sv
rtl/hrsc_root_cell.sv
rtl/hall_and_rtd_sample_converter.sv
tb/tb_hall_and_rtd_sample_converter.sv
